// ----- design/seed_chain_dp_defines.svh -----
// assertion macros for the seed chaining block
`ifndef SEED_CHAIN_DP_DEFINES_SVH
`define SEED_CHAIN_DP_DEFINES_SVH
`ifndef SYNTHESIS
`define SCD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SCD_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SCD_ASSERT(label, clk, rst_n, prop)
`define SCD_ASSERT_RST(label, clk, prop)
`endif
`endif

// ----- design/scd_pkg.sv -----
// shared constants and types of the seed chaining block
package scd_pkg;
  localparam int MaxSeeds = 64;
  localparam int IdxW = $clog2(MaxSeeds);
  localparam int CntW = $clog2(MaxSeeds + 1);
  localparam int ScoreW = 28;
  localparam int QueueDepth = 2;
  localparam int QPtrW = 1;
  localparam logic signed [ScoreW-1:0] ScoreMax = {1'b0, {(ScoreW-1){1'b1}}};
  localparam logic signed [ScoreW-1:0] ScoreNone = -28'sd20;

  typedef struct packed {
    logic [31:0] query_pos;
    logic [31:0] target_pos;
    logic [15:0] seed_len;
    logic        last_seed;
  } seed_t;
endpackage

// ----- design/scd_front.sv -----
// front end: accepts seed words into a short queue
module scd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scd_pkg::seed_t push_word,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output scd_pkg::seed_t head
);
  scd_pkg::seed_t q_r [scd_pkg::QueueDepth];
  logic [scd_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [scd_pkg::QPtrW:0] cnt_r;

  assign full = (cnt_r == 2'(scd_pkg::QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`include "seed_chain_dp_defines.svh"
  `SCD_ASSERT(a_no_overfill, clk, rst_n, push |-> !full)
  `SCD_ASSERT(a_no_underrun, clk, rst_n, pop |-> not_empty)
  `SCD_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !not_empty)
endmodule

// ----- design/scd_back.sv -----
// back end: sorted insert, chaining pass, traceback and result words
module scd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             avail,
  input  scd_pkg::seed_t                   word,
  output logic                             pop,
  output logic                             idle,
  output logic                             out_valid,
  output logic signed [scd_pkg::ScoreW-1:0] out_chain_score_x20,
  output logic [6:0]                       out_chain_length,
  output logic [31:0]                      out_query_pos,
  output logic [31:0]                      out_target_pos,
  output logic [15:0]                      out_seed_len,
  output logic                             out_overflowed,
  output logic                             out_last_of_chain
);
  localparam int IW = scd_pkg::IdxW;
  localparam int CW = scd_pkg::CntW;
  localparam int SW = scd_pkg::ScoreW;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_SHRD = 11'b00000000010,
    S_SHWR = 11'b00000000100,
    S_IRD  = 11'b00000001000,
    S_JRD  = 11'b00000010000,
    S_JCMP = 11'b00000100000,
    S_JUPD = 11'b00001000000,
    S_TRD  = 11'b00010000000,
    S_TWR  = 11'b00100000000,
    S_EMIT = 11'b01000000000,
    S_PRD  = 11'b10000000000
  } st_t;

  // seed memories, one write and one read port each
  logic [31:0] mq [scd_pkg::MaxSeeds];
  logic [31:0] mt [scd_pkg::MaxSeeds];
  logic [15:0] ml [scd_pkg::MaxSeeds];
  logic signed [SW-1:0] ms [scd_pkg::MaxSeeds];
  logic [IW-1:0] mp [scd_pkg::MaxSeeds];
  logic        mv [scd_pkg::MaxSeeds];
  logic [IW-1:0] path [scd_pkg::MaxSeeds];

  st_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic last_r, last_nxt;

  // registered read data
  logic [31:0] rq_r, rt_r;
  logic [15:0] rl_r;
  logic signed [SW-1:0] rs_r;
  logic [IW-1:0] rp_r;
  logic rv_r;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic wseed;
  logic [31:0] wq, wt;
  logic [15:0] wl;

  // current seed i
  logic [31:0] iq_r, it_r;
  logic [15:0] il_r;
  logic signed [SW-1:0] isc_r, isc_nxt;
  logic [IW-1:0] ip_r, ip_nxt;
  logic iv_r, iv_nxt;
  logic wsc;

  // candidate pipeline
  logic signed [SW+1:0] cand_r;
  logic cok_r;

  // best tracking and traceback
  logic signed [SW-1:0] best_r, best_nxt;
  logic [IW-1:0] bidx_r, bidx_nxt;
  logic have_r, have_nxt;
  logic [CW-1:0] n_r, n_nxt, k_r, k_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] pth_q;
  logic pwr;

  logic signed [34:0] gq, gt, diff;
  logic signed [SW+1:0] cand_w;

  always_comb begin
    gq = $signed({3'b0, iq_r}) - ($signed({3'b0, rq_r}) + $signed({19'b0, rl_r}) - 35'sd1);
    gt = $signed({3'b0, it_r}) - ($signed({3'b0, rt_r}) + $signed({19'b0, rl_r}) - 35'sd1);
    diff = (gq > gt) ? gq - gt : gt - gq;
    cand_w = (diff > 35'sd100000000) ? -30'sd300000000 :
      $signed({{2{rs_r[SW-1]}}, rs_r}) + $signed({10'b0, il_r, 4'b0} + {12'b0, il_r, 2'b0})
      - 30'(diff * 35'sd3);
  end

  always_ff @(posedge clk) begin
    if (wseed) begin
      mq[waddr] <= wq;
      mt[waddr] <= wt;
      ml[waddr] <= wl;
    end
    if (wsc) begin
      ms[i_r[IW-1:0]] <= isc_r;
      mp[i_r[IW-1:0]] <= ip_r;
      mv[i_r[IW-1:0]] <= iv_r;
    end
    if (pwr) path[n_r[IW-1:0]] <= cur_r;
    rq_r <= mq[raddr];
    rt_r <= mt[raddr];
    rl_r <= ml[raddr];
    rs_r <= ms[raddr];
    rp_r <= mp[raddr];
    rv_r <= mv[raddr];
    pth_q <= path[raddr];
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    pos_nxt = pos_r;
    i_nxt = i_r;
    j_nxt = j_r;
    last_nxt = last_r;
    isc_nxt = isc_r;
    ip_nxt = ip_r;
    iv_nxt = iv_r;
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    have_nxt = have_r;
    n_nxt = n_r;
    k_nxt = k_r;
    cur_nxt = cur_r;
    pop = 1'b0;
    raddr = '0;
    waddr = '0;
    wseed = 1'b0;
    wq = word.query_pos;
    wt = word.target_pos;
    wl = word.seed_len;
    wsc = 1'b0;
    pwr = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (avail) begin
          last_nxt = word.last_seed;
          if (cnt_r == CW'(scd_pkg::MaxSeeds)) begin
            ovf_nxt = 1'b1;
            pop = 1'b1;
            if (word.last_seed) begin
              i_nxt = '0;
              best_nxt = scd_pkg::ScoreNone;
              have_nxt = 1'b0;
              st_nxt = S_IRD;
            end
          end else begin
            pos_nxt = cnt_r;
            st_nxt = S_SHRD;
          end
        end
      end
      S_SHRD: begin
        if (pos_r == '0) begin
          waddr = '0;
          wseed = 1'b1;
          st_nxt = S_SHWR;
        end else begin
          raddr = IW'(pos_r - 1'b1);
          st_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        if (pos_r != '0 && rq_r > word.query_pos) begin
          waddr = pos_r[IW-1:0];
          wq = rq_r;
          wt = rt_r;
          wl = rl_r;
          wseed = 1'b1;
          pos_nxt = pos_r - 1'b1;
          st_nxt = S_SHRD;
        end else begin
          if (pos_r != '0) begin
            waddr = pos_r[IW-1:0];
            wseed = 1'b1;
          end
          pop = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (last_r) begin
            i_nxt = '0;
            best_nxt = scd_pkg::ScoreNone;
            have_nxt = 1'b0;
            st_nxt = S_IRD;
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_IRD: begin
        if (i_r == cnt_r) begin
          if (!have_r) begin
            st_nxt = S_EMIT;
            n_nxt = '0;
          end else begin
            n_nxt = '0;
            cur_nxt = bidx_r;
            st_nxt = S_TWR;
          end
        end else begin
          raddr = i_r[IW-1:0];
          j_nxt = i_r;
          st_nxt = S_JRD;
        end
      end
      S_JRD: begin
        if (j_r == i_r) begin
          isc_nxt = SW'({8'b0, rl_r, 4'b0} + {10'b0, rl_r, 2'b0});
          ip_nxt = '0;
          iv_nxt = 1'b0;
        end else if (cok_r && cand_r > $signed({{2{isc_r[SW-1]}}, isc_r})) begin
          isc_nxt = (cand_r > $signed({2'b0, scd_pkg::ScoreMax})) ? scd_pkg::ScoreMax
                                                                  : SW'(cand_r);
          ip_nxt = j_r[IW-1:0];
          iv_nxt = 1'b1;
        end
        if (j_r == '0) begin
          st_nxt = S_JUPD;
        end else begin
          raddr = IW'(j_r - 1'b1);
          j_nxt = j_r - 1'b1;
          st_nxt = S_JCMP;
        end
      end
      S_JCMP: begin
        st_nxt = S_JRD;
      end
      S_JUPD: begin
        wsc = 1'b1;
        if (isc_r > best_r) begin
          best_nxt = isc_r;
          bidx_nxt = i_r[IW-1:0];
          have_nxt = 1'b1;
        end
        i_nxt = i_r + 1'b1;
        st_nxt = S_IRD;
      end
      S_TWR: begin
        pwr = 1'b1;
        raddr = cur_r;
        n_nxt = n_r + 1'b1;
        st_nxt = S_TRD;
      end
      S_TRD: begin
        if (!rv_r || n_r >= cnt_r) begin
          k_nxt = '0;
          raddr = IW'(n_r - 1'b1);
          st_nxt = S_PRD;
        end else begin
          cur_nxt = rp_r;
          st_nxt = S_TWR;
        end
      end
      S_PRD: begin
        raddr = pth_q;
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!have_r || k_r + 1'b1 == n_r) begin
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
          st_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
          raddr = IW'(n_r - k_r - 2'd2);
          st_nxt = S_PRD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign idle = (st_r == S_IDLE) && !avail;
  assign out_chain_score_x20 = have_r ? best_r : scd_pkg::ScoreNone;
  assign out_chain_length = have_r ? 7'(n_r) : 7'd0;
  assign out_query_pos = have_r ? rq_r : 32'd0;
  assign out_target_pos = have_r ? rt_r : 32'd0;
  assign out_seed_len = have_r ? rl_r : 16'd0;
  assign out_overflowed = ovf_r;
  assign out_last_of_chain = !have_r || (k_r + 1'b1 == n_r);

  always_ff @(posedge clk) begin
    iq_r <= (st_r == S_JRD && j_r == i_r) ? rq_r : iq_r;
    it_r <= (st_r == S_JRD && j_r == i_r) ? rt_r : it_r;
    il_r <= (st_r == S_JRD && j_r == i_r) ? rl_r : il_r;
    cand_r <= cand_w;
    cok_r <= (gq > 35'sd0) && (gt > 35'sd0);
    isc_r <= isc_nxt;
    ip_r <= ip_nxt;
    iv_r <= iv_nxt;
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    cur_r <= cur_nxt;
    pos_r <= pos_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    n_r <= n_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      have_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      have_r <= have_nxt;
    end
  end

`include "seed_chain_dp_defines.svh"
  `SCD_ASSERT(a_onehot, clk, rst_n, $onehot(st_r))
  `SCD_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CW'(scd_pkg::MaxSeeds))
  `SCD_ASSERT(a_out_only_emit, clk, rst_n, out_valid |-> st_r == S_EMIT)
  `SCD_ASSERT(a_end_clears, clk, rst_n, (out_valid && out_last_of_chain) |=> cnt_r == '0)
endmodule

// ----- design/seed_chain_dp.sv -----
// seed chaining top level: command port, seed queue and chaining engine
// Seeds are taken when start is high and busy low; busy rises only while the
// two-word queue in front is full. Each seed is placed by a sorted insert
// that shifts the stored seeds with a larger query position, or is dropped
// once the store is full; the final seed then starts the chaining pass:
// a memory read and a compare per earlier seed for each seed, then the
// traceback of the chain seeds and the result words. Results appear with
// out_valid for one cycle each and cannot be held off.
module seed_chain_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [31:0]                      in_query_pos,
  input  logic [31:0]                      in_target_pos,
  input  logic [15:0]                      in_seed_len,
  input  logic                             in_last_seed,
  output logic                             out_valid,
  output logic signed [scd_pkg::ScoreW-1:0] out_chain_score_x20,
  output logic [6:0]                       out_chain_length,
  output logic [31:0]                      out_query_pos,
  output logic [31:0]                      out_target_pos,
  output logic [15:0]                      out_seed_len,
  output logic                             out_overflowed,
  output logic                             out_last_of_chain
);
  scd_pkg::seed_t in_word, head;
  logic full, not_empty, pop, idle;

  assign in_word = '{query_pos: in_query_pos, target_pos: in_target_pos,
                     seed_len: in_seed_len, last_seed: in_last_seed};
  assign busy = full;

  scd_front u_front (
    .clk(clk), .rst_n(rst_n), .push(start && !busy), .push_word(in_word),
    .full(full), .pop(pop), .not_empty(not_empty), .head(head)
  );

  scd_back u_back (
    .clk(clk), .rst_n(rst_n), .avail(not_empty), .word(head), .pop(pop), .idle(idle),
    .out_valid(out_valid), .out_chain_score_x20(out_chain_score_x20),
    .out_chain_length(out_chain_length), .out_query_pos(out_query_pos),
    .out_target_pos(out_target_pos), .out_seed_len(out_seed_len),
    .out_overflowed(out_overflowed), .out_last_of_chain(out_last_of_chain)
  );

`include "seed_chain_dp_defines.svh"
  `SCD_ASSERT(a_idle_no_out, clk, rst_n, idle |-> !out_valid)
  `SCD_ASSERT(a_busy_full, clk, rst_n, busy |-> !idle)
  `SCD_ASSERT(a_score_hi, clk, rst_n, out_valid |-> out_chain_score_x20 >= -28'sd20)
endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the seed chaining block
module testbench;
  localparam int CycleLimit = 1500000;

  typedef struct {
    logic signed [scd_pkg::ScoreW-1:0] score;
    logic [6:0]               clen;
    logic [31:0]              qpos;
    logic [31:0]              tpos;
    logic [15:0]              slen;
    logic                     ovf;
    logic                     last;
  } chain_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_query_pos = '0;
  logic [31:0] in_target_pos = '0;
  logic [15:0] in_seed_len = '0;
  logic        in_last_seed = 1'b0;
  logic        busy;
  logic        out_valid;
  logic signed [scd_pkg::ScoreW-1:0] out_chain_score_x20;
  logic [6:0]  out_chain_length;
  logic [31:0] out_query_pos;
  logic [31:0] out_target_pos;
  logic [15:0] out_seed_len;
  logic        out_overflowed;
  logic        out_last_of_chain;

  seed_chain_dp dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [31:0] held_q [scd_pkg::MaxSeeds];
  logic [31:0] held_t [scd_pkg::MaxSeeds];
  logic [15:0] held_len [scd_pkg::MaxSeeds];
  longint      chain_score [scd_pkg::MaxSeeds];
  int          chain_prev [scd_pkg::MaxSeeds];
  bit          has_prev [scd_pkg::MaxSeeds];
  int          held_count = 0;
  bit          dropped = 1'b0;

  chain_word_t expected_chain [$];
  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;

  task automatic hold_seed(logic [31:0] q, logic [31:0] t, logic [15:0] len);
    int pos;
    pos = held_count;
    while (pos > 0 && held_q[pos-1] > q) begin
      held_q[pos] = held_q[pos-1];
      held_t[pos] = held_t[pos-1];
      held_len[pos] = held_len[pos-1];
      pos--;
    end
    held_q[pos] = q;
    held_t[pos] = t;
    held_len[pos] = len;
    held_count++;
  endtask

  task automatic chain_seeds();
    longint own, gq, gt, diff, cand, best;
    int best_i, n, cur;
    int path [scd_pkg::MaxSeeds];
    chain_word_t w;
    best = -20;
    best_i = -1;
    for (int i = 0; i < held_count; i++) begin
      own = 20 * longint'(held_len[i]);
      chain_score[i] = own;
      has_prev[i] = 1'b0;
      chain_prev[i] = 0;
      for (int j = i - 1; j >= 0; j--) begin
        gq = longint'(held_q[i]) - (longint'(held_q[j]) + longint'(held_len[j]) - 1);
        gt = longint'(held_t[i]) - (longint'(held_t[j]) + longint'(held_len[j]) - 1);
        if (gq <= 0 || gt <= 0) continue;
        diff = gq > gt ? gq - gt : gt - gq;
        cand = chain_score[j] + own - 3 * diff;
        if (cand > longint'(scd_pkg::ScoreMax)) cand = longint'(scd_pkg::ScoreMax);
        if (cand > chain_score[i]) begin
          chain_score[i] = cand;
          chain_prev[i] = j;
          has_prev[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < held_count; i++) begin
      if (chain_score[i] > best) begin
        best = chain_score[i];
        best_i = i;
      end
    end
    if (best_i < 0) begin
      w = '{scd_pkg::ScoreNone, 7'd0, 32'd0, 32'd0, 16'd0, dropped, 1'b1};
      expected_chain.push_back(w);
    end else begin
      n = 0;
      cur = best_i;
      forever begin
        path[n++] = cur;
        if (!has_prev[cur] || n >= held_count) break;
        cur = chain_prev[cur];
      end
      for (int k = 0; k < n; k++) begin
        cur = path[n-1-k];
        w.score = best[scd_pkg::ScoreW-1:0];
        w.clen = n > 127 ? 7'd127 : n[6:0];
        w.qpos = held_q[cur];
        w.tpos = held_t[cur];
        w.slen = held_len[cur];
        w.ovf = dropped;
        w.last = (k == n - 1);
        expected_chain.push_back(w);
      end
    end
    held_count = 0;
    dropped = 1'b0;
  endtask

  task automatic send_seed(logic [31:0] q, logic [31:0] t, logic [15:0] len, bit last);
    if (!no_idle && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_query_pos <= q;
    in_target_pos <= t;
    in_seed_len <= len;
    in_last_seed <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (held_count < scd_pkg::MaxSeeds) hold_seed(q, t, len);
    else dropped = 1'b1;
    if (last) chain_seeds();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_chain.size() != 0) @(posedge clk);
  endtask

  // well-formed chain set with random content, optionally shuffled
  task automatic send_chain_set(int n, bit shuffle);
    logic [31:0] qs [$];
    logic [31:0] ts [$];
    logic [15:0] ls [$];
    logic [31:0] q, t;
    logic [15:0] len;
    int k;
    q = $urandom_range(0, 100000);
    t = $urandom();
    for (int i = 0; i < n; i++) begin
      len = $urandom_range(0, 99) < 5 ? 16'($urandom()) : 16'($urandom_range(1, 40));
      qs.push_back(q);
      ts.push_back(t);
      ls.push_back(len);
      q = q + len + $urandom_range(0, 60);
      t = $urandom_range(0, 9) == 0 ? $urandom() : t + len + $urandom_range(0, 60);
    end
    if (shuffle) begin
      for (int i = n - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        {qs[i], qs[k]} = {qs[k], qs[i]};
        {ts[i], ts[k]} = {ts[k], ts[i]};
        {ls[i], ls[k]} = {ls[k], ls[i]};
      end
    end
    for (int i = 0; i < n; i++) send_seed(qs[i], ts[i], ls[i], i == n - 1);
  endtask

  task automatic test_directed();
    send_seed(32'd0, 32'd0, 16'd1, 1'b1);
    send_seed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_seed(32'd5, 32'd5, 16'd0, 1'b1);
    send_seed(32'd0, 32'd0, 16'd10, 1'b0);
    send_seed(32'd20, 32'd30, 16'd10, 1'b0);
    send_seed(32'd40, 32'd45, 16'd10, 1'b1);
    send_seed(32'd100, 32'd100, 16'd5, 1'b0);
    send_seed(32'd100, 32'd200, 16'd5, 1'b0);
    send_seed(32'd0, 32'd300, 16'd5, 1'b0);
    send_seed(32'd100, 32'd50, 16'd7, 1'b1);
    send_seed(32'd0, 32'hFFFF_FF00, 16'hFFFF, 1'b0);
    send_seed(32'hFFFF_FFFF, 32'd0, 16'hFFFF, 1'b0);
    send_seed(32'hFFFF_0000, 32'hFFFF_FFF0, 16'd2, 1'b1);
    send_seed(32'd10, 32'd10, 16'd4, 1'b0);
    send_seed(32'd10, 32'd10, 16'd4, 1'b0);
    send_seed(32'd20, 32'd20, 16'd4, 1'b1);
    send_seed(32'd0, 32'd0, 16'hFFFF, 1'b0);
    send_seed(32'h0001_0000, 32'h0001_0000, 16'hFFFF, 1'b1);
    drain();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < scd_pkg::MaxSeeds + 3; i++)
      send_seed($urandom_range(0, 5000), $urandom_range(0, 5000),
                16'($urandom_range(1, 30)), i == scd_pkg::MaxSeeds + 2);
    drain();
    for (int i = 0; i < scd_pkg::MaxSeeds + 1; i++)
      send_seed(32'(i * 20), 32'(i * 21), 16'd8, i == scd_pkg::MaxSeeds);
    drain();
  endtask

  task automatic test_random(int items);
    int sent, n;
    sent = 0;
    while (sent < items) begin
      no_idle = (sent > items / 3 && sent < items / 2);
      if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(0, 19) == 0 ? $urandom_range(9, 24) : $urandom_range(1, 8);
        send_chain_set(n, $urandom_range(0, 1));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          send_seed($urandom(), $urandom(), 16'($urandom()), i == n - 1);
      end
      sent += n;
      if ($urandom_range(0, 29) == 0) drain();
    end
    no_idle = 1'b0;
    drain();
  endtask

  always @(posedge clk) begin
    chain_word_t w;
    if (rst_n && out_valid) begin
      if (expected_chain.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected chain word: q=%h", out_query_pos);
      end else begin
        w = expected_chain.pop_front();
        if (out_chain_score_x20 !== w.score || out_chain_length !== w.clen ||
            out_query_pos !== w.qpos || out_target_pos !== w.tpos ||
            out_seed_len !== w.slen || out_overflowed !== w.ovf ||
            out_last_of_chain !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %h %h %h %b %b got %0d %0d %h %h %h %b %b",
                     w.score, w.clen, w.qpos, w.tpos, w.slen, w.ovf, w.last,
                     out_chain_score_x20, out_chain_length, out_query_pos,
                     out_target_pos, out_seed_len, out_overflowed, out_last_of_chain);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(340);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_chain.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/scd_pkg.sv
design/scd_front.sv
design/scd_back.sv
design/seed_chain_dp.sv
bench/testbench.sv
